// File: hw/rtl/sha_pkg.sv
// sha_pkg: shared types and constants for the sha-256 byte stream hasher
// round constants, initial hash values, controller states and command struct
// no dependencies

package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } sha_state_t;

  typedef struct packed {
    logic       take_byte;   // store a message byte
    logic       put_pad;     // store 0x80 marker
    logic       put_zero;    // store a zero pad byte
    logic       put_len;     // place length in last eight bytes
    logic       start;       // load working vars from chaining words
    logic       round;       // run one round
    logic       fold;        // add working vars into chaining words
    logic       clear;       // back to initial state after digest
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;        // bytes in block
    logic       last_round;  // round counter at 63
  } sha_stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// File: hw/rtl/sha256_byte_stream_hasher_unit.sv
// sha256_byte_stream_hasher_unit: top level of the sha-256 byte stream hasher
// instantiates sha_ctrl and sha_datapath, depends on sha_pkg

// Takes one message byte per accepted word and hashes it with SHA-256. A byte
// word that does not fill the 64-byte block is stored in the block; the word that
// fills it starts a compression of 64 rounds, one round per cycle through a
// single round unit, then a fold of the result into the chaining words.
// The end of message adds padding: the 0x80 marker and zero bytes are
// written one per cycle up to the length field, then one or two
// compressions run. The digest leaves as four 64-bit big-endian words,
// index 0 first, last_word on index 3, after which the hasher returns to
// its initial state. in_stall is high while a block is compressed, padded
// or the digest is being delivered.

module sha256_byte_stream_hasher_unit import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  sha_cmd_t     cmd;
  sha_stat_t    stat;
  logic [255:0] digest;
  logic [1:0]   idx;

  sha_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .byte_present   (in_byte_present),
    .end_of_message (in_end_of_message),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_idx        (idx),
    .stat           (stat),
    .cmd            (cmd)
  );

  sha_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .byte_in (in_byte_value),
    .stat    (stat),
    .digest  (digest)
  );

  // most significant word first
  always_comb begin
    case (idx)
      2'd0:    out_digest_word = digest[255:192];
      2'd1:    out_digest_word = digest[191:128];
      2'd2:    out_digest_word = digest[127:64];
      default: out_digest_word = digest[63:0];
    endcase
  end

  assign out_word_index = idx;
  assign out_last_word  = (idx == 2'd3);

endmodule

// File: hw/rtl/sha_datapath.sv
// sha_datapath: block buffer, 16-word message schedule window, round unit
// and chaining words; acts on commands from sha_ctrl
// depends on sha_pkg

module sha_datapath import sha_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sha_cmd_t     cmd,
  input  logic [7:0]   byte_in,
  output sha_stat_t    stat,
  output logic [255:0] digest
);

  logic [31:0] w_r [16];          // block words, then schedule window
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;
  logic [63:0] bits_r;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;
  logic [7:0]  wr_byte;
  logic        wr_en;

  always_comb begin
    s0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    big1  = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1    = v_r[7] + big1 + ch + ROUND_K[rnd_r] + w_r[0];
    big0  = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2    = big0 + maj;
    wr_en = cmd.take_byte | cmd.put_pad | cmd.put_zero;
    wr_byte = cmd.take_byte ? byte_in : (cmd.put_pad ? PAD_BYTE : 8'h00);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (fill_r[1:0])
        2'd0: w_r[fill_r[5:2]][31:24] <= wr_byte;
        2'd1: w_r[fill_r[5:2]][23:16] <= wr_byte;
        2'd2: w_r[fill_r[5:2]][15:8]  <= wr_byte;
        default: w_r[fill_r[5:2]][7:0] <= wr_byte;
      endcase
    end
    // length goes in with the byte at position 55, which sits in word 13
    if (cmd.put_len) begin
      w_r[14] <= bits_r[63:32];
      w_r[15] <= bits_r[31:0];
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      for (int i = 1; i < 8; i++) v_r[i] <= v_r[i-1];
      v_r[4] <= v_r[3] + t1;
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
      fill_r <= '0;
      rnd_r  <= '0;
      bits_r <= '0;
    end else begin
      if (wr_en) fill_r <= fill_r + 6'd1;
      if (cmd.take_byte) bits_r <= bits_r + 64'd8;
      if (cmd.start) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  assign stat.fill       = fill_r;
  assign stat.last_round = (rnd_r == 6'd63);
  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4], h_r[5], h_r[6], h_r[7]};

endmodule

// File: hw/rtl/sha_ctrl.sv
// sha_ctrl: sequencer for byte intake, compression rounds, padding and
// digest output handshake
// depends on sha_pkg

module sha_ctrl import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       byte_present,
  input  logic       end_of_message,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [1:0] out_idx,
  input  sha_stat_t  stat,
  output sha_cmd_t   cmd
);

  sha_state_t state_r, state_nxt;
  logic       fin_r, fin_nxt;      // finish pending after current compression
  logic       lenblk_r, lenblk_nxt;// current compression holds the length
  logic       pad_r, pad_nxt;      // padding under way, marker placed
  logic [1:0] idx_r, idx_nxt;
  logic       acc;

  assign acc = in_valid && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    lenblk_nxt = lenblk_r;
    pad_nxt    = pad_r;
    idx_nxt    = idx_r;
    unique case (state_r)
      ST_IDLE: if (acc) begin
        fin_nxt    = end_of_message;
        lenblk_nxt = 1'b0;
        if (byte_present && stat.fill == 6'd63) state_nxt = ST_ROUND;
        else if (end_of_message) state_nxt = ST_PAD;
      end
      ST_ROUND: if (stat.last_round) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (lenblk_r) begin
          state_nxt = ST_OUT;
          idx_nxt   = 2'd0;
          pad_nxt   = 1'b0;
        end else if (fin_r || pad_r) state_nxt = ST_PAD;
        else state_nxt = ST_IDLE;
      end
      ST_PAD: begin
        pad_nxt = 1'b1;
        // marker first, then zeros to the end or to the length field
        if (!fin_r) begin
          if (stat.fill == 6'd55) begin
            state_nxt  = ST_ROUND;
            lenblk_nxt = 1'b1;
          end else if (stat.fill == 6'd63) begin
            state_nxt = ST_ROUND;
          end
        end else if (stat.fill == 6'd63) begin
          state_nxt = ST_ROUND;
          fin_nxt   = 1'b0;
        end else if (stat.fill == 6'd55) begin
          state_nxt  = ST_ROUND;
          lenblk_nxt = 1'b1;
          fin_nxt    = 1'b0;
        end else begin
          fin_nxt = 1'b0;
        end
      end
      ST_OUT: if (!out_stall) begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    out_idx   = idx_r;
    unique case (state_r)
      ST_IDLE: if (acc) begin
        cmd.take_byte = byte_present;
        cmd.start     = byte_present && stat.fill == 6'd63;
      end
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD:  cmd.fold  = 1'b1;
      ST_PAD: begin
        cmd.put_pad  = fin_r;
        cmd.put_zero = !fin_r;
        cmd.put_len  = (stat.fill == 6'd55);
        cmd.start    = (stat.fill == 6'd63) || (stat.fill == 6'd55);
      end
      ST_OUT: cmd.clear = !out_stall && idx_r == 2'd3;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fin_r    <= 1'b0;
      lenblk_r <= 1'b0;
      pad_r    <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      fin_r    <= fin_nxt;
      lenblk_r <= lenblk_nxt;
      pad_r    <= pad_nxt;
      idx_r    <= idx_nxt;
    end
  end

  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_OUT)) else $error("stray output");
  a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && stat.last_round) |=> (state_r == ST_FOLD))
    else $error("rounds did not end in fold");

endmodule
